@@ hdl/qgemv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgemv_pkg
// Shared constants and types of the block-scaled quantized vector-matrix unit.
// ----------------------------------------------------------------------------
package qgemv_pkg;

   // accumulator store geometry
   localparam int MAX_COLS = 1024;
   localparam int COL_W    = $clog2(MAX_COLS);

   // field widths
   localparam int ACT_W    = 15;
   localparam int WGT_W    = 15;
   localparam int PROD_W   = ACT_W + WGT_W;
   localparam int SCALE_W  = 32;
   localparam int ACC_W    = 64;
   localparam int IDX_W    = 10;
   localparam int FRAC_W   = 24;
   localparam int ENTRY_W  = ACC_W + 1;

   // packed word widths
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 80;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACT_SCALE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_SCALE = 2'd2;

   // scale reset value, 1.0 in Q8.24
   localparam logic [SCALE_W-1:0] SCALE_ONE = 32'h0100_0000;

   // partial product steps of the emit multiplier
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_MAG  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_LAST = 3'd5;

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_TERM  = 6'b000100,
      ST_ADD   = 6'b001000,
      ST_MUL   = 6'b010000,
      ST_ROUND = 6'b100000
   } state_type;

endpackage

@@ hdl/qgemv_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qgemv_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qgemv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ hdl/quantized_gemv_block_scaled.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Timing: an item of the final row shows its result on rsp once the emit
//   multiplier has run four 32x32 partial products in turn and rounded.
// Flow: items of other rows pass read, term and add with write back to the
//   accumulator RAM; a new word is taken only when the sequencer is idle.
// Reset: synchronous, active high; clears the sequencer, column counter,
//   sets first_row and loads block_mode 0 and both scales with 1.0.
// ----------------------------------------------------------------------------
// quantized_gemv_block_scaled
// Vector times row-major matrix with per-tensor or per-block Q8.24 scales,
// saturating 64-bit accumulators held in a RAM, one result per final-row word.
// ----------------------------------------------------------------------------
module quantized_gemv_block_scaled (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input words
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   // activation[14:0], weight[29:15], block_scale[61:30], zero pad
   input  wire logic [qgemv_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                 req_tlast,   // last_col
   input  wire logic                                 req_tuser,   // last_row
   // result words
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // col_index[9:0], value[73:10], zero pad
   output      logic [qgemv_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output      logic                                 rsp_tlast,   // last
   output      logic                                 rsp_tuser,   // overflow
   // configuration writes
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [qgemv_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [qgemv_pkg::SCALE_W-1:0]        csr_data
);

   localparam logic [qgemv_pkg::COL_W-1:0] COL_MAX =
      qgemv_pkg::COL_W'(qgemv_pkg::MAX_COLS - 1);

   // control
   qgemv_pkg::state_type              state_ff, state_in;
   logic [qgemv_pkg::COL_W-1:0]       col_cnt_ff, col_cnt_in;
   logic                              first_row_ff, first_row_in;
   logic [qgemv_pkg::STEP_W-1:0]      step_ff, step_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // configuration registers
   logic                              block_mode_ff;
   logic [qgemv_pkg::SCALE_W-1:0]     act_scale_ff;
   logic [qgemv_pkg::SCALE_W-1:0]     weight_scale_ff;

   // item payload
   logic signed [qgemv_pkg::ACT_W-1:0]  act_ff, act_in;
   logic signed [qgemv_pkg::WGT_W-1:0]  wgt_ff, wgt_in;
   logic [qgemv_pkg::SCALE_W-1:0]       bs_ff, bs_in;
   logic                                last_col_ff, last_col_in;
   logic                                last_row_ff, last_row_in;
   logic [qgemv_pkg::COL_W-1:0]         col_ff, col_in;

   // datapath
   logic signed [qgemv_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [qgemv_pkg::ACC_W-1:0]         acc_ff, acc_in;
   logic                                ovf_ff, ovf_in;
   logic [qgemv_pkg::ACC_W-1:0]         term_ff, term_in;
   logic [qgemv_pkg::ACC_W-1:0]         sum_ff, sum_in;
   logic [qgemv_pkg::ACC_W-1:0]         factor_ff, factor_in;
   logic [qgemv_pkg::ACC_W-1:0]         mag_ff, mag_in;
   logic                                neg_ff, neg_in;
   logic [qgemv_pkg::ACC_W-1:0]         pp_ff, pp_in;
   logic [2*qgemv_pkg::ACC_W-1:0]       wide_ff, wide_in;

   // result register
   logic [qgemv_pkg::IDX_W-1:0]         out_col_ff, out_col_in;
   logic [qgemv_pkg::ACC_W-1:0]         out_val_ff, out_val_in;
   logic                                out_ovf_ff, out_ovf_in;
   logic                                out_last_ff, out_last_in;

   // memory port
   logic                                ram_we;
   logic                                ram_re;
   logic [qgemv_pkg::ENTRY_W-1:0]       ram_wdata;
   logic [qgemv_pkg::ENTRY_W-1:0]       ram_rdata;

   // combinational helpers
   logic                                req_fire;
   logic                                out_free;
   logic signed [62:0]                  term_blk;
   logic [qgemv_pkg::ACC_W-1:0]         add_raw;
   logic                                add_sat;
   logic [qgemv_pkg::ACC_W-1:0]         add_res;
   logic [qgemv_pkg::SCALE_W-1:0]       mul_a;
   logic [qgemv_pkg::SCALE_W-1:0]       mul_b;
   logic [qgemv_pkg::ACC_W-1:0]         mul_p;
   logic [1:0]                          mul_sel;
   logic [1:0]                          acc_sel;
   logic [2*qgemv_pkg::ACC_W-1:0]       pp_shift;
   logic [2*qgemv_pkg::ACC_W-1:0]       rnd;
   logic [qgemv_pkg::ACC_W-1:0]         q_lo;
   logic                                q_hi_nz;
   logic [qgemv_pkg::ACC_W-1:0]         q_lim;
   logic                                emit_sat;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == qgemv_pkg::ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // accumulator and overflow mark store
   qgemv_ram #(
      .WIDTH (qgemv_pkg::ENTRY_W),
      .DEPTH (qgemv_pkg::MAX_COLS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (col_cnt_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (col_cnt_ff),
      .rd_data (ram_rdata)
   );

   assign ram_re    = req_fire;
   assign ram_we    = (state_ff == qgemv_pkg::ST_ADD);
   assign ram_wdata = {add_sat || ovf_ff, add_res};

   // block-mode term, signed product times unsigned scale
   assign term_blk = $signed(prod_ff) * $signed({1'b0, bs_ff});

   // saturating accumulate
   assign add_raw = acc_ff + term_ff;
   assign add_sat = (acc_ff[63] == term_ff[63]) && (add_raw[63] != acc_ff[63]);
   always_comb begin
      if (add_sat) begin
         add_res = acc_ff[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
         add_res = add_raw;
      end
   end

   // shared 32x32 multiplier for the emit product
   assign mul_sel = 2'(step_ff - 3'd1);
   assign acc_sel = 2'(step_ff - 3'd2);
   always_comb begin
      unique case (mul_sel)
         2'd0: begin
            mul_a = mag_ff[31:0];
            mul_b = factor_ff[31:0];
         end
         2'd1: begin
            mul_a = mag_ff[63:32];
            mul_b = factor_ff[31:0];
         end
         2'd2: begin
            mul_a = mag_ff[31:0];
            mul_b = factor_ff[63:32];
         end
         default: begin
            mul_a = mag_ff[63:32];
            mul_b = factor_ff[63:32];
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // weight of the partial product being summed
   always_comb begin
      unique case (acc_sel)
         2'd0:    pp_shift = {64'd0, pp_ff};
         2'd1:    pp_shift = {32'd0, pp_ff, 32'd0};
         2'd2:    pp_shift = {32'd0, pp_ff, 32'd0};
         default: pp_shift = {pp_ff, 64'd0};
      endcase
   end

   // round half away from zero and saturate
   assign rnd      = wide_ff + 128'(64'h0080_0000);
   assign q_lo     = rnd[qgemv_pkg::FRAC_W +: qgemv_pkg::ACC_W];
   assign q_hi_nz  = |rnd[127:qgemv_pkg::FRAC_W + qgemv_pkg::ACC_W];
   assign q_lim    = neg_ff ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
   assign emit_sat = q_hi_nz || (q_lo > q_lim);

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      col_cnt_in   = col_cnt_ff;
      first_row_in = first_row_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      act_in       = act_ff;
      wgt_in       = wgt_ff;
      bs_in        = bs_ff;
      last_col_in  = last_col_ff;
      last_row_in  = last_row_ff;
      col_in       = col_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      ovf_in       = ovf_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      factor_in    = factor_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      pp_in        = pp_ff;
      wide_in      = wide_ff;
      out_col_in   = out_col_ff;
      out_val_in   = out_val_ff;
      out_ovf_in   = out_ovf_ff;
      out_last_in  = out_last_ff;

      // result word leaves
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         qgemv_pkg::ST_IDLE: begin
            // take a word and start the accumulator read
            if (req_fire) begin
               act_in      = req_tdata[14:0];
               wgt_in      = req_tdata[29:15];
               bs_in       = req_tdata[61:30];
               last_col_in = req_tlast;
               last_row_in = req_tuser;
               col_in      = col_cnt_ff;
               state_in    = qgemv_pkg::ST_READ;
            end
         end
         qgemv_pkg::ST_READ: begin
            // first row starts from zero instead of the stored entry
            prod_in  = act_ff * wgt_ff;
            acc_in   = first_row_ff ? '0 : ram_rdata[qgemv_pkg::ACC_W-1:0];
            ovf_in   = first_row_ff ? 1'b0 : ram_rdata[qgemv_pkg::ACC_W];
            state_in = qgemv_pkg::ST_TERM;
         end
         qgemv_pkg::ST_TERM: begin
            if (block_mode_ff) begin
               term_in   = {term_blk[62], term_blk};
               factor_in = {32'd0, act_scale_ff};
            end else begin
               term_in   = {{(qgemv_pkg::ACC_W - qgemv_pkg::PROD_W){prod_ff[29]}}, prod_ff};
               factor_in = act_scale_ff * weight_scale_ff;
            end
            state_in = qgemv_pkg::ST_ADD;
         end
         qgemv_pkg::ST_ADD: begin
            // write back, advance the column
            sum_in  = add_res;
            ovf_in  = add_sat || ovf_ff;
            wide_in = '0;
            step_in = qgemv_pkg::STEP_MAG;
            if (last_col_ff) begin
               col_cnt_in   = '0;
               first_row_in = last_row_ff;
            end else if (col_cnt_ff == COL_MAX) begin
               col_cnt_in = '0;
            end else begin
               col_cnt_in = col_cnt_ff + 1'b1;
            end
            state_in = last_row_ff ? qgemv_pkg::ST_MUL : qgemv_pkg::ST_IDLE;
         end
         qgemv_pkg::ST_MUL: begin
            // magnitude, then four partial products, each registered before summing
            if (step_ff == qgemv_pkg::STEP_MAG) begin
               neg_in = sum_ff[63];
               mag_in = sum_ff[63] ? (64'd0 - sum_ff) : sum_ff;
            end
            if (step_ff >= 3'd1 && step_ff <= 3'd4) begin
               pp_in = mul_p;
            end
            if (step_ff >= 3'd2) begin
               wide_in = wide_ff + pp_shift;
            end
            if (step_ff == qgemv_pkg::STEP_LAST) begin
               state_in = qgemv_pkg::ST_ROUND;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         qgemv_pkg::ST_ROUND: begin
            // load the result register once it is free
            if (out_free) begin
               out_col_in   = qgemv_pkg::IDX_W'(col_ff);
               out_ovf_in   = ovf_ff || emit_sat;
               out_last_in  = last_col_ff;
               rsp_valid_in = 1'b1;
               if (emit_sat) begin
                  out_val_in = neg_ff ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
               end else begin
                  out_val_in = neg_ff ? (64'd0 - q_lo) : q_lo;
               end
               state_in = qgemv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = qgemv_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qgemv_pkg::ST_IDLE;
         col_cnt_ff   <= '0;
         first_row_ff <= 1'b1;
         step_ff      <= qgemv_pkg::STEP_MAG;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_cnt_ff   <= col_cnt_in;
         first_row_ff <= first_row_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         block_mode_ff   <= 1'b0;
         act_scale_ff    <= qgemv_pkg::SCALE_ONE;
         weight_scale_ff <= qgemv_pkg::SCALE_ONE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            qgemv_pkg::CSR_BLOCK_MODE: begin
               block_mode_ff <= csr_data[0];
            end
            qgemv_pkg::CSR_ACT_SCALE: begin
               act_scale_ff <= csr_data;
            end
            qgemv_pkg::CSR_WEIGHT_SCALE: begin
               weight_scale_ff <= csr_data;
            end
            default: begin
               block_mode_ff <= block_mode_ff;
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      wgt_ff      <= wgt_in;
      bs_ff       <= bs_in;
      last_col_ff <= last_col_in;
      last_row_ff <= last_row_in;
      col_ff      <= col_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      ovf_ff      <= ovf_in;
      term_ff     <= term_in;
      sum_ff      <= sum_in;
      factor_ff   <= factor_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      pp_ff       <= pp_in;
      wide_ff     <= wide_in;
      out_col_ff  <= out_col_in;
      out_val_ff  <= out_val_in;
      out_ovf_ff  <= out_ovf_in;
      out_last_ff <= out_last_in;
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, out_val_ff, out_col_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

`ifndef SYNTHESIS
   // a taken word always starts the accumulator read sequence
   a_fire_to_read: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == qgemv_pkg::ST_READ)
      else $error("word taken without entering read");

   // column counter never leaves the store
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_cnt_ff <= COL_MAX)
      else $error("column counter out of range");

   // a new result only comes from the rounding step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == qgemv_pkg::ST_ROUND))
      else $error("result raised outside rounding");

   // a row end that is not the final row leaves first_row clear
   a_row_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == qgemv_pkg::ST_ADD && last_col_ff && !last_row_ff) |=> !first_row_ff)
      else $error("first_row still set after row end");
`endif

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the block-scaled vector-matrix unit. A directed table
// covers scale and operand extremes, accumulator and emit saturation and a mode
// flip inside a vector. Random vectors with random configs and random stalls
// on both sides follow.
// Each result is compared with its table value or an in-bench prediction.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYC    = 12;
   localparam int SETTLE_CYC   = 24;
   localparam int IDLE_PCT     = 12;
   localparam int HOLD_CYC     = 400;
   localparam int STALL_LIMIT  = 5000;
   localparam int RANDOM_WORDS = 620;
   localparam int ACT_RANGE    = 9841;

   localparam logic [qgemv_pkg::ACC_W-1:0] VAL_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [qgemv_pkg::ACC_W-1:0] VAL_MIN     = 64'h8000_0000_0000_0000;
   localparam logic [qgemv_pkg::ACT_W-1:0] OPND_POS    = 15'd9841;
   localparam logic [qgemv_pkg::ACT_W-1:0] OPND_NEG    = 15'h598F;   // -9841
   localparam logic [qgemv_pkg::ACT_W-1:0] PATTERN_MIN = 15'h4000;
   localparam logic [qgemv_pkg::ACT_W-1:0] PATTERN_MAX = 15'h3FFF;

   typedef enum logic { ROW_WORD, ROW_CSR } row_kind_type;

   typedef struct packed {
      logic [qgemv_pkg::ACT_W-1:0]   act;
      logic [qgemv_pkg::WGT_W-1:0]   wgt;
      logic [qgemv_pkg::SCALE_W-1:0] bscale;
      logic                          lcol;
      logic                          lrow;
   } gemv_word_type;

   typedef struct packed {
      logic [qgemv_pkg::IDX_W-1:0] col;
      logic [qgemv_pkg::ACC_W-1:0] value;
      logic                        ovf;
      logic                        last;
   } col_result_type;

   typedef struct packed {
      row_kind_type                    kind;
      gemv_word_type                   word;
      logic [qgemv_pkg::CSR_IDX_W-1:0] reg_idx;
      logic [qgemv_pkg::SCALE_W-1:0]   reg_val;
      logic                            typed;
      col_result_type                  res;
   } dir_row_type;

   // dut ports
   logic                             clock;
   logic                             reset       = 1'b1;
   logic                             req_tvalid  = 1'b0;
   wire                              req_tready;
   logic [qgemv_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   logic                             req_tlast   = 1'b0;
   logic                             req_tuser   = 1'b0;
   wire                              rsp_tvalid;
   logic                             rsp_tready  = 1'b0;
   wire  [qgemv_pkg::RSP_DATA_W-1:0] rsp_tdata;
   wire                              rsp_tlast;
   wire                              rsp_tuser;
   logic                             csr_valid   = 1'b0;
   wire                              csr_ready;
   logic [qgemv_pkg::CSR_IDX_W-1:0]  csr_index   = '0;
   logic [qgemv_pkg::SCALE_W-1:0]    csr_data    = '0;

   // mirror of the datapath state
   logic signed [qgemv_pkg::ACC_W-1:0] acc_store [0:qgemv_pkg::MAX_COLS-1];
   logic                               ovf_store [0:qgemv_pkg::MAX_COLS-1];
   bit                                 col_written [0:qgemv_pkg::MAX_COLS-1];
   int unsigned                        col_ptr;
   bit                                 fresh_row;
   logic                               mode_block;
   logic [qgemv_pkg::SCALE_W-1:0]      scale_act;
   logic [qgemv_pkg::SCALE_W-1:0]      scale_wgt;

   col_result_type pending_cols[$];
   dir_row_type    dir_table[$];
   int             errors       = 0;
   int             words_sent   = 0;
   int             quiet_cycles = 0;
   bit             calm         = 1'b0;
   bit             hold_rsp     = 1'b0;

   quantized_gemv_block_scaled u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // accumulate one word into its column, emit on the final row
   task automatic gemv_predict(input gemv_word_type w, output bit emits,
                               output col_result_type r);
      logic signed [qgemv_pkg::ACC_W-1:0] xs, ws, term, acc;
      logic [qgemv_pkg::ACC_W:0]          sum;
      logic                               ovf;
      logic [qgemv_pkg::ACC_W-1:0]        mag, factor, lim;
      logic [2*qgemv_pkg::ACC_W-1:0]      prod;
      int unsigned                        j;
      j    = col_ptr;
      xs   = {{(qgemv_pkg::ACC_W-qgemv_pkg::ACT_W){w.act[qgemv_pkg::ACT_W-1]}}, w.act};
      ws   = {{(qgemv_pkg::ACC_W-qgemv_pkg::WGT_W){w.wgt[qgemv_pkg::WGT_W-1]}}, w.wgt};
      term = xs * ws;
      if (mode_block)
         term = term * $signed({32'd0, w.bscale});
      acc = fresh_row ? '0 : acc_store[j];
      ovf = fresh_row ? 1'b0 : ovf_store[j];
      // saturating add, the extra bit differing from the sign marks overflow
      sum = {acc[qgemv_pkg::ACC_W-1], acc} + {term[qgemv_pkg::ACC_W-1], term};
      if (sum[qgemv_pkg::ACC_W] != sum[qgemv_pkg::ACC_W-1]) begin
         ovf = 1'b1;
         acc = sum[qgemv_pkg::ACC_W] ? VAL_MIN : VAL_MAX;
      end else begin
         acc = sum[qgemv_pkg::ACC_W-1:0];
      end
      acc_store[j]   = acc;
      ovf_store[j]   = ovf;
      col_written[j] = 1'b1;
      emits = w.lrow;
      r = '0;
      if (w.lrow) begin
         // magnitude times factor, round half away from zero, saturate
         factor = mode_block ? {32'd0, scale_act} : {32'd0, scale_act} * {32'd0, scale_wgt};
         mag    = acc[qgemv_pkg::ACC_W-1] ? -acc : acc;
         prod   = ({64'd0, mag} * {64'd0, factor} + (128'd1 << (qgemv_pkg::FRAC_W - 1)))
                  >> qgemv_pkg::FRAC_W;
         lim    = acc[qgemv_pkg::ACC_W-1] ? VAL_MIN : VAL_MAX;
         r.col  = j[qgemv_pkg::IDX_W-1:0];
         r.last = w.lcol;
         r.ovf  = ovf;
         if (prod[2*qgemv_pkg::ACC_W-1:qgemv_pkg::ACC_W] != 0 ||
             prod[qgemv_pkg::ACC_W-1:0] > lim) begin
            r.ovf   = 1'b1;
            r.value = acc[qgemv_pkg::ACC_W-1] ? VAL_MIN : VAL_MAX;
         end else begin
            r.value = acc[qgemv_pkg::ACC_W-1] ? -prod[qgemv_pkg::ACC_W-1:0]
                                              : prod[qgemv_pkg::ACC_W-1:0];
         end
      end
      if (w.lcol) begin
         col_ptr   = 0;
         fresh_row = w.lrow;
      end else begin
         col_ptr = (j + 1 >= qgemv_pkg::MAX_COLS) ? 0 : j + 1;
      end
   endtask

   // send one word, then queue its expected result if it is a final-row word
   task automatic issue_word(input gemv_word_type w, input bit typed,
                             input col_result_type typed_res);
      bit             emits;
      col_result_type r;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, w.bscale, w.wgt, w.act};
      req_tlast  <= w.lcol;
      req_tuser  <= w.lrow;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      gemv_predict(w, emits, r);
      if (emits)
         pending_cols.push_back(typed ? typed_res : r);
   endtask

   // stop sending and let the block run dry
   task automatic drain_results;
      req_tvalid <= 1'b0;
      while (pending_cols.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // one register write
   task automatic write_reg(input logic [qgemv_pkg::CSR_IDX_W-1:0] idx,
                            input logic [qgemv_pkg::SCALE_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      unique case (idx)
         qgemv_pkg::CSR_BLOCK_MODE:   mode_block = val[0];
         qgemv_pkg::CSR_ACT_SCALE:    scale_act  = val;
         qgemv_pkg::CSR_WEIGHT_SCALE: scale_wgt  = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // directed table rows
   function automatic void add_word(input logic [qgemv_pkg::ACT_W-1:0] act,
                                    input logic [qgemv_pkg::WGT_W-1:0] wgt,
                                    input logic [qgemv_pkg::SCALE_W-1:0] bs,
                                    input logic lc, input logic lr,
                                    input logic typed,
                                    input logic [qgemv_pkg::IDX_W-1:0] col,
                                    input logic [qgemv_pkg::ACC_W-1:0] val,
                                    input logic ovf);
      dir_row_type row;
      row             = '0;
      row.kind        = ROW_WORD;
      row.word.act    = act;
      row.word.wgt    = wgt;
      row.word.bscale = bs;
      row.word.lcol   = lc;
      row.word.lrow   = lr;
      row.typed       = typed;
      row.res.col     = col;
      row.res.value   = val;
      row.res.ovf     = ovf;
      row.res.last    = lc;
      dir_table.push_back(row);
   endfunction

   function automatic void add_reg(input logic [qgemv_pkg::CSR_IDX_W-1:0] idx,
                                   input logic [qgemv_pkg::SCALE_W-1:0] val);
      dir_row_type row;
      row         = '0;
      row.kind    = ROW_CSR;
      row.reg_idx = idx;
      row.reg_val = val;
      dir_table.push_back(row);
   endfunction

   // random operands, biased toward the edges
   function automatic logic [qgemv_pkg::ACT_W-1:0] pick_operand;
      logic [31:0] raw;
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(4))
               0:       pick_operand = OPND_POS;
               1:       pick_operand = OPND_NEG;
               2:       pick_operand = PATTERN_MIN;
               3:       pick_operand = PATTERN_MAX;
               default: pick_operand = '0;
            endcase
         end
         1: begin
            raw = $urandom;
            pick_operand = raw[qgemv_pkg::ACT_W-1:0];
         end
         default: begin
            raw = $urandom_range(2 * ACT_RANGE) - ACT_RANGE;
            pick_operand = raw[qgemv_pkg::ACT_W-1:0];
         end
      endcase
   endfunction

   function automatic logic [qgemv_pkg::SCALE_W-1:0] pick_scale;
      case ($urandom_range(5))
         0:       pick_scale = '1;
         1:       pick_scale = '0;
         2:       pick_scale = qgemv_pkg::SCALE_ONE;
         3:       pick_scale = $urandom;
         default: pick_scale = $urandom_range(32'h0200_0000);
      endcase
   endfunction

   // new random settings, only once the block is idle
   task automatic shuffle_config;
      drain_results();
      if ($urandom_range(1))
         write_reg(qgemv_pkg::CSR_BLOCK_MODE, $urandom_range(1));
      if ($urandom_range(1))
         write_reg(qgemv_pkg::CSR_ACT_SCALE, pick_scale());
      if ($urandom_range(1))
         write_reg(qgemv_pkg::CSR_WEIGHT_SCALE, pick_scale());
   endtask

   // one vector of rows; noisy vectors get odd row lengths and stray flags
   task automatic run_vector(input int ncols, input int nrows, input bit noisy);
      gemv_word_type w;
      int            len;
      int            k;
      for (int r = 0; r < nrows; r++) begin
         len = ncols;
         if (noisy && $urandom_range(2) == 0)
            len = $urandom_range(ncols + 3, 1);
         // never reach a column that holds no sum yet
         if (!fresh_row) begin
            k = 0;
            while (k < len && col_written[k])
               k++;
            len = k;
         end
         if (noisy && r > 0 && $urandom_range(5) == 0) begin
            drain_results();
            write_reg(qgemv_pkg::CSR_BLOCK_MODE, $urandom_range(1));
         end
         for (int c = 0; c < len; c++) begin
            w.act    = pick_operand();
            w.wgt    = pick_operand();
            case ($urandom_range(3))
               0:       w.bscale = '1;
               1:       w.bscale = $urandom;
               default: w.bscale = $urandom_range(32'h0200_0000);
            endcase
            w.lcol = (c == len - 1);
            w.lrow = (r == nrows - 1);
            if (noisy && $urandom_range(9) == 0)
               w.lrow = ~w.lrow;
            issue_word(w, 1'b0, '0);
         end
      end
   endtask

   // result side: random stalls, one long hold, field checks
   initial begin : rsp_side
      col_result_type got;
      col_result_type want;
      int             hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.col   = rsp_tdata[qgemv_pkg::IDX_W-1:0];
            got.value = rsp_tdata[qgemv_pkg::IDX_W +: qgemv_pkg::ACC_W];
            got.ovf   = rsp_tuser;
            got.last  = rsp_tlast;
            if (pending_cols.size() == 0) begin
               $error("result word for column %0d with nothing expected", got.col);
               errors++;
            end else begin
               want = pending_cols.pop_front();
               if (got.col !== want.col) begin
                  $error("col_index: expected %0d, actual %0d", want.col, got.col);
                  errors++;
               end
               if (got.value !== want.value) begin
                  $error("value: expected %0d, actual %0d",
                         $signed(want.value), $signed(got.value));
                  errors++;
               end
               if (got.ovf !== want.ovf) begin
                  $error("overflow: expected %0b, actual %0b", want.ovf, got.ovf);
                  errors++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, got.last);
                  errors++;
               end
            end
         end
         if (hold_rsp && hold_left == 0) begin
            hold_left = HOLD_CYC;
            hold_rsp  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !reset && (calm || $urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // stimulus
   initial begin : stimulus
      dir_row_type row;
      int          base;
      int          calm_from;
      int          hold_at;
      bit          hold_done;
      int          ncols;
      mode_block = 1'b0;
      scale_act  = qgemv_pkg::SCALE_ONE;
      scale_wgt  = qgemv_pkg::SCALE_ONE;
      col_ptr    = 0;
      fresh_row  = 1'b1;
      hold_done  = 1'b0;
      repeat (RESET_CYC) @(posedge clock);
      reset <= 1'b0;

      // reset settings: per-tensor mode, both scales 1.0
      add_word(15'd1, 15'd1, '0, 1'b1, 1'b1, 1'b1, '0, 64'h0000_0000_0100_0000, 1'b0);
      add_word(OPND_POS, OPND_NEG, '1, 1'b1, 1'b1, 1'b1, '0, -(64'sd96845281 <<< 24), 1'b0);
      add_word(PATTERN_MIN, PATTERN_MIN, '0, 1'b1, 1'b1, 1'b1, '0, 64'h0010_0000_0000_0000, 1'b0);
      // zero activation
      add_word('0, 15'h7FFF, '1, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0);
      // two rows of three columns
      add_word(15'd120, -15'sd45, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0);
      add_word(OPND_NEG, 15'd77, '0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0);
      add_word(15'h7FFF, PATTERN_MAX, '0, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0);
      add_word(15'd33, 15'd2, '0, 1'b0, 1'b1, 1'b0, '0, '0, 1'b0);
      add_word(OPND_POS, OPND_POS, '0, 1'b0, 1'b1, 1'b0, '0, '0, 1'b0);
      add_word(15'd5, -15'sd7, '0, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0);
      // block mode: nine largest terms saturate the accumulator
      add_reg(qgemv_pkg::CSR_BLOCK_MODE, 32'd1);
      add_reg(qgemv_pkg::CSR_ACT_SCALE, '1);
      for (int i = 0; i < 8; i++)
         add_word(PATTERN_MIN, PATTERN_MIN, '1, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0);
      add_word(PATTERN_MIN, PATTERN_MIN, '1, 1'b1, 1'b1, 1'b1, '0, VAL_MAX, 1'b1);
      // mode flips between the rows of one vector
      add_word(15'd100, -15'sd3, 32'h0080_0000, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0);
      add_reg(qgemv_pkg::CSR_BLOCK_MODE, 32'd0);
      add_reg(qgemv_pkg::CSR_ACT_SCALE, 32'h0080_0000);
      add_word(15'd7, 15'd5, '0, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0);
      // largest per-tensor factor: emit saturates both ways
      add_reg(qgemv_pkg::CSR_ACT_SCALE, '1);
      add_reg(qgemv_pkg::CSR_WEIGHT_SCALE, '1);
      add_word(OPND_POS, OPND_POS, '0, 1'b1, 1'b1, 1'b1, '0, VAL_MAX, 1'b1);
      add_word(OPND_NEG, OPND_POS, '0, 1'b1, 1'b1, 1'b1, '0, VAL_MIN, 1'b1);
      // zero scale
      add_reg(qgemv_pkg::CSR_ACT_SCALE, '0);
      add_word(15'd5, 15'd5, '0, 1'b1, 1'b1, 1'b1, '0, '0, 1'b0);
      add_reg(qgemv_pkg::CSR_ACT_SCALE, qgemv_pkg::SCALE_ONE);
      add_reg(qgemv_pkg::CSR_WEIGHT_SCALE, qgemv_pkg::SCALE_ONE);

      for (int i = 0; i < dir_table.size(); i++) begin
         row = dir_table[i];
         if (row.kind == ROW_CSR) begin
            drain_results();
            write_reg(row.reg_idx, row.reg_val);
         end else begin
            issue_word(row.word, row.typed, row.res);
         end
      end

      // random vectors, mostly well formed, some noisy
      base      = words_sent;
      calm_from = base + 250;
      hold_at   = base + 450;
      while (words_sent < base + RANDOM_WORDS) begin
         if ($urandom_range(3) == 0)
            shuffle_config();
         calm = (words_sent >= calm_from && words_sent < calm_from + 150);
         if (!hold_done && words_sent >= hold_at) begin
            // receiver stops while a long final row keeps coming
            hold_done = 1'b1;
            hold_rsp  = 1'b1;
            run_vector(40, 1, 1'b0);
         end
         ncols = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
         run_vector(ncols, $urandom_range(5, 1), $urandom_range(4) == 0);
      end
      calm = 1'b0;

      drain_results();
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
